FILE: src/vlqr_pkg.sv
// ----------------------------------------------------------------------------
// vlqr_pkg
// Shared types, register indexes, sequencer states and helpers for the
// velocity controller with integral action.
// ----------------------------------------------------------------------------
`default_nettype none

package vlqr_pkg;

    // Input beat: one command
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] measured_velocity;
        logic signed [31:0] reference_velocity;
        logic        [23:0] elapsed_time;
    } t_cmd;

    // Output beat: one drive value
    typedef struct packed {
        logic signed [31:0] drive;
    } t_rsp;

    // Configuration write beat
    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg;

    // Command codes
    localparam logic OP_CALC  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // Register indexes
    typedef enum logic [2:0] {
        REG_VELOCITY_GAIN   = 3'd0,
        REG_INTEGRAL_GAIN   = 3'd1,
        REG_OUTPUT_LIMIT    = 3'd2,
        REG_INTEGRAL_ENABLE = 3'd3,
        REG_INTEGRAL_CLAMP  = 3'd4,
        REG_ERROR_DEADBAND  = 3'd5,
        REG_WINDUP_DECAY    = 3'd6
    } t_reg_idx;

    // Register file contents
    typedef struct packed {
        logic signed [31:0] velocity_gain;
        logic signed [31:0] integral_gain;
        logic        [30:0] output_limit;
        logic               integral_enable;
        logic        [30:0] integral_clamp;
        logic        [30:0] error_deadband;
        logic        [15:0] windup_decay;
    } t_cfg_regs;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB,
        ST_T,
        ST_INC,
        ST_DHI,
        ST_DLO,
        ST_ACC,
        ST_OUT
    } t_state;

    localparam int unsigned MUL_W  = 33;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned SUM_W  = 50;

    // Symmetric clamp of a wide sum to +/- lim
    function automatic logic signed [31:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic        [30:0]      lim
    );
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        logic signed [31:0]      res;
        pos = $signed({{(SUM_W-31){1'b0}}, lim});
        neg = -pos;
        if (v > pos) begin
            res = $signed({1'b0, lim});
        end else if (v < neg) begin
            res = -$signed({1'b0, lim});
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/vlqr_chan_if.sv
// ----------------------------------------------------------------------------
// vlqr_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vlqr_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: src/velocity_lqr_integral_controller.sv
// ----------------------------------------------------------------------------
// velocity_lqr_integral_controller
// Velocity loop with proportional feedback and a clamped, deadbanded integral.
// ----------------------------------------------------------------------------
// A calculate command is taken only when the block is idle. Its drive value is
// presented as the block returns to idle, and the next command can be taken in
// that same cycle; a new command is not taken while one is in progress. The
// command makes five passes through the single registered 33x33 multiplier
// (feedback, error times time, gain times that, and two partial products for
// the anti-windup decay), then an integral update step and the output clamp.
// A reset command goes straight to the output step. The output register lets
// the block take the next command while a drive value still waits downstream.
// If that value is still waiting when the next result is due, the block holds
// in its output step until the waiting beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_lqr_integral_controller (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    vlqr_chan_if.sink   i_cmd,
    vlqr_chan_if.source o_rsp,
    vlqr_chan_if.sink   i_cfg
);

    localparam int unsigned MW = vlqr_pkg::MUL_W;
    localparam int unsigned PW = vlqr_pkg::PROD_W;
    localparam int unsigned SW = vlqr_pkg::SUM_W;

    vlqr_pkg::t_cfg_regs w_regs;
    vlqr_pkg::t_state    r_state;
    vlqr_pkg::t_state    n_state;

    logic signed [MW-1:0] w_mul_a;
    logic signed [MW-1:0] w_mul_b;
    logic signed [PW-1:0] w_prod;

    // Item registers
    logic signed [31:0] r_e;
    logic        [23:0] r_dt;
    logic signed [47:0] r_fb;
    logic signed [47:0] r_inc;
    logic signed [48:0] r_dhi;
    logic signed [31:0] r_integ;
    logic               r_add_int;
    logic               r_out_valid;
    logic signed [31:0] r_drive;

    // Combinational datapath terms
    logic signed [32:0] w_diff;
    logic signed [31:0] w_e_sat;
    logic        [16:0] w_keep;
    logic        [31:0] w_mag;
    logic               w_int_on;
    logic               w_do_int;
    logic               w_same;
    logic               w_decay_on;
    logic signed [48:0] w_dec;
    logic signed [48:0] w_inc_sel;
    logic signed [SW-1:0] w_integ_sum;
    logic signed [SW-1:0] w_out_sum;
    logic               w_accept;
    logic               w_out_load;

    vlqr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (w_regs)
    );

    vlqr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Saturate the velocity error to 32 bits
    assign w_diff  = 33'(i_cmd.payload.reference_velocity)
                   - 33'(i_cmd.payload.measured_velocity);
    assign w_e_sat = (w_diff[32] != w_diff[31])
                   ? (w_diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                   : w_diff[31:0];

    // Fraction of an increment kept after decay
    assign w_keep = 17'h1_0000 - {1'b0, w_regs.windup_decay};

    // Integration decisions, taken with the integral before its update
    assign w_mag      = r_e[31] ? (32'd0 - r_e) : r_e;
    assign w_int_on   = w_regs.integral_enable && (r_dt != 24'd0);
    assign w_do_int   = w_int_on && (w_mag > {1'b0, w_regs.error_deadband});
    assign w_same     = ((r_e > 0) && (r_integ > 0)) || ((r_e < 0) && (r_integ < 0));
    assign w_decay_on = (w_regs.windup_decay != 16'd0) && w_same;

    // Recombine the decayed increment from its two partial products
    assign w_dec       = r_dhi + $signed({32'd0, w_prod[32:16]});
    assign w_inc_sel   = w_decay_on ? w_dec : 49'(r_inc);
    assign w_integ_sum = SW'(r_integ) + SW'(w_inc_sel);
    assign w_out_sum   = SW'(r_fb) + (r_add_int ? SW'(r_integ) : '0);

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_load = (r_state == vlqr_pkg::ST_OUT) && (!r_out_valid || o_rsp.ready);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vlqr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier operand selection
    always_comb begin
        n_state     = r_state;
        w_mul_a     = '0;
        w_mul_b     = '0;
        i_cmd.ready = 1'b0;
        case (r_state)
            vlqr_pkg::ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_state = (i_cmd.payload.opcode == vlqr_pkg::OP_RESET)
                            ? vlqr_pkg::ST_OUT : vlqr_pkg::ST_FB;
                end
            end
            vlqr_pkg::ST_FB: begin
                w_mul_a = MW'(w_regs.velocity_gain);
                w_mul_b = MW'(r_e);
                n_state = vlqr_pkg::ST_T;
            end
            vlqr_pkg::ST_T: begin
                w_mul_a = MW'(r_e);
                w_mul_b = $signed({{(MW-24){1'b0}}, r_dt});
                n_state = vlqr_pkg::ST_INC;
            end
            vlqr_pkg::ST_INC: begin
                w_mul_a = MW'(w_regs.integral_gain);
                w_mul_b = MW'($signed(w_prod[55:24]));
                n_state = vlqr_pkg::ST_DHI;
            end
            vlqr_pkg::ST_DHI: begin
                w_mul_a = MW'($signed(w_prod[63:32]));
                w_mul_b = $signed({{(MW-17){1'b0}}, w_keep});
                n_state = vlqr_pkg::ST_DLO;
            end
            vlqr_pkg::ST_DLO: begin
                w_mul_a = $signed({{(MW-16){1'b0}}, r_inc[15:0]});
                w_mul_b = $signed({{(MW-17){1'b0}}, w_keep});
                n_state = vlqr_pkg::ST_ACC;
            end
            vlqr_pkg::ST_ACC: begin
                n_state = vlqr_pkg::ST_OUT;
            end
            vlqr_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = vlqr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vlqr_pkg::ST_IDLE;
            end
        endcase
    end

    // Integral accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (w_accept && (i_cmd.payload.opcode == vlqr_pkg::OP_RESET)) begin
            r_integ <= '0;
        end else if ((r_state == vlqr_pkg::ST_ACC) && w_do_int) begin
            r_integ <= vlqr_pkg::clamp_sym(w_integ_sum, w_regs.integral_clamp);
        end
    end

    // Item datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e       <= w_e_sat;
            r_dt      <= i_cmd.payload.elapsed_time;
            r_fb      <= '0;
            r_add_int <= 1'b0;
        end
        case (r_state)
            vlqr_pkg::ST_T: begin
                r_fb <= $signed(w_prod[63:16]);
            end
            vlqr_pkg::ST_DHI: begin
                r_inc <= $signed(w_prod[63:16]);
            end
            vlqr_pkg::ST_DLO: begin
                r_dhi <= $signed(w_prod[48:0]);
            end
            vlqr_pkg::ST_ACC: begin
                r_add_int <= w_int_on;
            end
            default: begin
            end
        endcase
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_drive <= vlqr_pkg::clamp_sym(w_out_sum, w_regs.output_limit);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.payload.drive = r_drive;

endmodule

`default_nettype wire

FILE: src/vlqr_mul.sv
// ----------------------------------------------------------------------------
// vlqr_mul
// Shared 33x33 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module vlqr_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [vlqr_pkg::MUL_W-1:0]   i_a,
    input  wire logic signed [vlqr_pkg::MUL_W-1:0]   i_b,
    output logic signed      [vlqr_pkg::PROD_W-1:0]  o_prod
);

    logic signed [vlqr_pkg::PROD_W-1:0] r_prod;

    // Register the product every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: src/vlqr_cfg.sv
// ----------------------------------------------------------------------------
// vlqr_cfg
// Configuration register file: decodes write beats by index.
// ----------------------------------------------------------------------------
`default_nettype none

module vlqr_cfg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    vlqr_chan_if.sink               i_cfg,
    output vlqr_pkg::t_cfg_regs     o_regs
);

    vlqr_pkg::t_cfg_regs r_regs;

    assign i_cfg.ready = 1'b1;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                vlqr_pkg::REG_VELOCITY_GAIN: begin
                    r_regs.velocity_gain <= $signed(i_cfg.payload.data);
                end
                vlqr_pkg::REG_INTEGRAL_GAIN: begin
                    r_regs.integral_gain <= $signed(i_cfg.payload.data);
                end
                vlqr_pkg::REG_OUTPUT_LIMIT: begin
                    r_regs.output_limit <= i_cfg.payload.data[30:0];
                end
                vlqr_pkg::REG_INTEGRAL_ENABLE: begin
                    r_regs.integral_enable <= i_cfg.payload.data[0];
                end
                vlqr_pkg::REG_INTEGRAL_CLAMP: begin
                    r_regs.integral_clamp <= i_cfg.payload.data[30:0];
                end
                vlqr_pkg::REG_ERROR_DEADBAND: begin
                    r_regs.error_deadband <= i_cfg.payload.data[30:0];
                end
                vlqr_pkg::REG_WINDUP_DECAY: begin
                    r_regs.windup_decay <= i_cfg.payload.data[15:0];
                end
                default: begin
                    r_regs <= r_regs;
                end
            endcase
        end
    end

    assign o_regs = r_regs;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the velocity controller with integral action. A
// short table of directed beats and register writes runs first, then random
// command streams under several register settings and handshake idle mixes.
// Drives are checked against table values or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned     CYCLE_LIMIT = 300000;
    localparam int unsigned     DRAIN_WAIT  = 20;
    localparam logic [2:0]      REG_UNUSED  = 3'd7;
    localparam logic [23:0]     DT_MAX      = 24'hFF_FFFF;
    localparam logic [31:0]     V_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0]     V_MIN       = 32'h8000_0000;
    localparam logic [31:0]     ONE         = 32'h0001_0000;
    localparam longint          SAT_HI      = 64'sd2147483647;
    localparam longint          SAT_LO      = -64'sd2147483648;

    // One row of the directed table: a register write or a command beat
    typedef struct {
        bit              is_reg;
        logic [2:0]      idx;
        logic [31:0]     data;
        vlqr_pkg::t_cmd  cmd;
        bit              has_exp;
        logic [31:0]     exp_drive;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    vlqr_chan_if #(.t_payload(vlqr_pkg::t_cmd)) cmd_if ();
    vlqr_chan_if #(.t_payload(vlqr_pkg::t_rsp)) rsp_if ();
    vlqr_chan_if #(.t_payload(vlqr_pkg::t_cfg)) cfg_if ();

    velocity_lqr_integral_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Predictor state: register shadow and integral accumulator
    vlqr_pkg::t_cfg_regs ctl;
    longint              integ_acc;
    logic [31:0]         drive_q[$];
    t_row                dir_rows[$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct;
    int unsigned dst_idle_pct;
    int unsigned hold_cycles = 0;
    int          err_bias    = 1;

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("velocity_lqr_integral_controller test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic longint limit_to(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Update the register shadow; unknown indexes are dropped
    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            vlqr_pkg::REG_VELOCITY_GAIN:   ctl.velocity_gain   = data;
            vlqr_pkg::REG_INTEGRAL_GAIN:   ctl.integral_gain   = data;
            vlqr_pkg::REG_OUTPUT_LIMIT:    ctl.output_limit    = data[30:0];
            vlqr_pkg::REG_INTEGRAL_ENABLE: ctl.integral_enable = data[0];
            vlqr_pkg::REG_INTEGRAL_CLAMP:  ctl.integral_clamp  = data[30:0];
            vlqr_pkg::REG_ERROR_DEADBAND:  ctl.error_deadband  = data[30:0];
            vlqr_pkg::REG_WINDUP_DECAY:    ctl.windup_decay    = data[15:0];
            default: ;
        endcase
    endfunction

    // Work out the drive value for one command and advance the integral
    function automatic logic [31:0] predict_drive(input vlqr_pkg::t_cmd c);
        longint err;
        longint mag;
        longint t_q;
        longint inc;
        longint total;
        bit     same_sign;
        if (c.opcode == vlqr_pkg::OP_RESET) begin
            integ_acc = 0;
            return '0;
        end
        err = longint'($signed(c.reference_velocity)) - longint'($signed(c.measured_velocity));
        if (err > SAT_HI) begin
            err = SAT_HI;
        end else if (err < SAT_LO) begin
            err = SAT_LO;
        end
        total = (longint'($signed(ctl.velocity_gain)) * err) >>> 16;
        if (ctl.integral_enable && c.elapsed_time != '0) begin
            mag = (err < 0) ? -err : err;
            if (mag > longint'(ctl.error_deadband)) begin
                t_q = (err * longint'(c.elapsed_time)) >>> 24;
                inc = (longint'($signed(ctl.integral_gain)) * t_q) >>> 16;
                same_sign = (err > 0 && integ_acc > 0) || (err < 0 && integ_acc < 0);
                if (ctl.windup_decay != '0 && same_sign) begin
                    inc = (inc * (longint'(65536) - longint'(ctl.windup_decay))) >>> 16;
                end
                integ_acc = limit_to(integ_acc + inc, longint'(ctl.integral_clamp));
            end
            total = total + integ_acc;
        end
        total = limit_to(total, longint'(ctl.output_limit));
        return total[31:0];
    endfunction

    // Release both senders, then hold until every drive value has come back
    task automatic drain();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        cfg_if.valid = 1'b0;
        wait (drive_q.size() == 0);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        drain();
        @(negedge i_clk);
        cfg_if.valid         = 1'b1;
        cfg_if.payload.index = idx;
        cfg_if.payload.data  = data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // Offer one command beat, with random idle cycles ahead of it
    task automatic push_cmd(input vlqr_pkg::t_cmd c, input bit has_exp,
                            input logic [31:0] exp_drive);
        logic [31:0] predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            cfg_if.valid = 1'b0;
            cmd_if.valid = 1'b0;
        end
        @(negedge i_clk);
        cfg_if.valid   = 1'b0;
        cmd_if.valid   = 1'b1;
        cmd_if.payload = c;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predicted = predict_drive(c);
        drive_q.push_back(has_exp ? exp_drive : predicted);
    endtask

    function automatic void add_reg(input logic [2:0] idx, input logic [31:0] data);
        t_row r;
        r = '{default: '0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_cmd(input logic op, input logic [31:0] meas,
                                    input logic [31:0] target, input logic [23:0] dt,
                                    input bit has_exp, input logic [31:0] exp_drive);
        t_row r;
        r = '{default: '0};
        r.cmd.opcode             = op;
        r.cmd.measured_velocity  = meas;
        r.cmd.reference_velocity = target;
        r.cmd.elapsed_time       = dt;
        r.has_exp                = has_exp;
        r.exp_drive              = exp_drive;
        dir_rows.push_back(r);
    endfunction

    // Directed table: register extremes, saturation and each integral corner
    function automatic void build_directed();
        // all registers zero after reset: output clamp forces zero
        add_cmd(vlqr_pkg::OP_CALC,  32'h0, ONE,   DT_MAX, 1, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC,  V_MIN, V_MAX, DT_MAX, 1, 32'h0);
        add_cmd(vlqr_pkg::OP_RESET, V_MAX, V_MIN, DT_MAX, 1, 32'h0);
        // unit gain, full-scale limit: error saturates both ways
        add_reg(vlqr_pkg::REG_VELOCITY_GAIN, ONE);
        add_reg(vlqr_pkg::REG_OUTPUT_LIMIT, V_MAX);
        add_cmd(vlqr_pkg::OP_CALC, V_MIN, V_MAX, 24'h0, 1, 32'h7FFF_FFFF);
        add_cmd(vlqr_pkg::OP_CALC, V_MAX, V_MIN, 24'h0, 1, 32'h8000_0001);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, 32'h0, 24'h0, 1, 32'h0);
        // most negative gain
        add_reg(vlqr_pkg::REG_VELOCITY_GAIN, V_MIN);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, ONE,   24'h0, 1, 32'h8000_0001);
        add_cmd(vlqr_pkg::OP_CALC, V_MAX, V_MIN, 24'h0, 1, 32'h7FFF_FFFF);
        // integration on, no deadband, no decay
        add_reg(vlqr_pkg::REG_VELOCITY_GAIN, 32'h0000_8000);
        add_reg(vlqr_pkg::REG_INTEGRAL_GAIN, ONE);
        add_reg(vlqr_pkg::REG_INTEGRAL_ENABLE, 32'h1);
        add_reg(vlqr_pkg::REG_INTEGRAL_CLAMP, V_MAX);
        add_reg(vlqr_pkg::REG_ERROR_DEADBAND, 32'h0);
        add_reg(vlqr_pkg::REG_WINDUP_DECAY, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0,         ONE,           DT_MAX,      0, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0,         ONE,           DT_MAX,      0, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0003_0000, 32'h0,         24'h80_0000, 0, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0,         32'h0005_0000, 24'h0,       0, 32'h0);
        // deadband: inside, on the edge, one step outside
        add_reg(vlqr_pkg::REG_ERROR_DEADBAND, 32'h0002_0000);
        add_cmd(vlqr_pkg::OP_CALC, ONE,   32'h0,         DT_MAX, 0, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, 32'h0002_0000, DT_MAX, 0, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, 32'h0002_0001, DT_MAX, 0, 32'h0);
        // anti-windup decay on same-sign and opposite-sign steps
        add_reg(vlqr_pkg::REG_WINDUP_DECAY, 32'h0000_8000);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0,         32'h0004_0000, DT_MAX, 0, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0004_0000, 32'h0,         DT_MAX, 0, 32'h0);
        add_reg(vlqr_pkg::REG_WINDUP_DECAY, 32'h0000_FFFF);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, 32'h0008_0000, DT_MAX, 0, 32'h0);
        // lowered clamp: integral holds outside it until the next update
        add_reg(vlqr_pkg::REG_INTEGRAL_CLAMP, 32'h0000_0100);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, ONE,           DT_MAX,   0, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, 32'h0003_0000, 24'h1000, 0, 32'h0);
        // integration off: integral kept but not added
        add_reg(vlqr_pkg::REG_INTEGRAL_ENABLE, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, 32'h0003_0000, DT_MAX, 0, 32'h0);
        // largest integral gain, unknown register index is dropped
        add_reg(vlqr_pkg::REG_INTEGRAL_ENABLE, 32'h1);
        add_reg(vlqr_pkg::REG_INTEGRAL_GAIN, V_MAX);
        add_reg(vlqr_pkg::REG_INTEGRAL_CLAMP, V_MAX);
        add_reg(vlqr_pkg::REG_ERROR_DEADBAND, 32'h0);
        add_reg(vlqr_pkg::REG_WINDUP_DECAY, 32'h0);
        add_reg(REG_UNUSED, 32'hFFFF_FFFF);
        add_cmd(vlqr_pkg::OP_CALC,  V_MIN, V_MAX, DT_MAX, 0, 32'h0);
        add_cmd(vlqr_pkg::OP_RESET, 32'h0, ONE,   DT_MAX, 1, 32'h0);
        // zero output limit, then a tight one with most negative integral gain
        add_reg(vlqr_pkg::REG_OUTPUT_LIMIT, 32'h0);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, ONE, DT_MAX, 1, 32'h0);
        add_reg(vlqr_pkg::REG_OUTPUT_LIMIT, ONE);
        add_reg(vlqr_pkg::REG_INTEGRAL_GAIN, V_MIN);
        add_cmd(vlqr_pkg::OP_CALC, 32'h0, 32'h0004_0000, DT_MAX, 0, 32'h0);
    endfunction

    function automatic logic [31:0] small_signed(input int unsigned span);
        return 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    // Pick a gain: full range, near unity, or one of the extremes
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return V_MIN;
            2:       return V_MAX;
            default: return small_signed(32'h0004_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_mag();
        case ($urandom_range(5))
            0:       return V_MAX;
            1:       return {1'b0, 31'($urandom())};
            2:       return 32'h0;
            default: return 32'($urandom_range(32'h0000_1000, 32'h0080_0000));
        endcase
    endfunction

    // Program a fresh random setting into every register
    task automatic program_random_setting();
        logic [31:0] band;
        logic [31:0] decay;
        write_reg(vlqr_pkg::REG_VELOCITY_GAIN, pick_gain());
        write_reg(vlqr_pkg::REG_INTEGRAL_GAIN, pick_gain());
        write_reg(vlqr_pkg::REG_OUTPUT_LIMIT, pick_mag());
        write_reg(vlqr_pkg::REG_INTEGRAL_ENABLE, ($urandom_range(3) != 0) ? 32'h1 : 32'h0);
        write_reg(vlqr_pkg::REG_INTEGRAL_CLAMP, pick_mag());
        case ($urandom_range(3))
            0:       band = 32'h0;
            1:       band = {1'b0, 31'($urandom())};
            default: band = 32'($urandom_range(0, 32'h0000_8000));
        endcase
        write_reg(vlqr_pkg::REG_ERROR_DEADBAND, band);
        case ($urandom_range(3))
            0:       decay = 32'h0;
            1:       decay = 32'h0000_FFFF;
            default: decay = 32'($urandom_range(0, 16'hFFFF));
        endcase
        write_reg(vlqr_pkg::REG_WINDUP_DECAY, decay);
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED, $urandom());
        end
    endtask

    // Mostly small tracking errors with a drifting sign, some full-range noise
    function automatic vlqr_pkg::t_cmd random_cmd();
        vlqr_pkg::t_cmd c;
        logic [31:0]    target;
        logic [31:0]    delta;
        if ($urandom_range(29) == 0) begin
            err_bias = -err_bias;
        end
        c.opcode = ($urandom_range(19) == 0) ? vlqr_pkg::OP_RESET : vlqr_pkg::OP_CALC;
        if ($urandom_range(4) == 0) begin
            c.measured_velocity  = $urandom();
            c.reference_velocity = $urandom();
        end else begin
            target = small_signed(32'h0040_0000);
            delta  = 32'($urandom_range(0, 32'h0004_0000)) - 32'h0000_8000;
            c.reference_velocity = target;
            c.measured_velocity  = (err_bias > 0) ? target - delta : target + delta;
        end
        case ($urandom_range(7))
            0:       c.elapsed_time = 24'h0;
            1:       c.elapsed_time = 24'($urandom());
            2:       c.elapsed_time = DT_MAX;
            default: c.elapsed_time = 24'($urandom_range(1, 24'h00_4000));
        endcase
        return c;
    endfunction

    // Response ready: random idling, or a long hold-off when one is armed
    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            rsp_if.ready = 1'b0;
            hold_cycles  = hold_cycles - 1;
        end else begin
            rsp_if.ready = ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Check each drive beat against the oldest prediction
    always @(posedge i_clk) begin
        logic [31:0] exp_drive;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("drive %h with nothing outstanding",
                                          rsp_if.payload.drive));
            end else begin
                exp_drive = drive_q.pop_front();
                if (rsp_if.payload.drive !== exp_drive) begin
                    report_mismatch($sformatf("drive %h, predicted %h",
                                              rsp_if.payload.drive, exp_drive));
                end
            end
        end
    end

    // Main sequence
    initial begin
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        rsp_if.ready   = 1'b0;
        ctl            = '0;
        integ_acc      = 0;
        src_idle_pct   = 16;
        dst_idle_pct   = 67;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        build_directed();
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                push_cmd(dir_rows[i].cmd, dir_rows[i].has_exp, dir_rows[i].exp_drive);
            end
        end

        // Random streams: three idle mixes, three register settings each
        for (int mix = 0; mix < 3; mix++) begin
            case (mix)
                0: begin
                    src_idle_pct = 16;
                    dst_idle_pct = 67;
                end
                1: begin
                    src_idle_pct = 67;
                    dst_idle_pct = 16;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            for (int setting = 0; setting < 3; setting++) begin
                program_random_setting();
                for (int n = 0; n < 150; n++) begin
                    // stall the output long enough to back up the input
                    if (mix == 0 && setting == 1 && n == 50) begin
                        hold_cycles = 400;
                    end
                    // let the pipe run dry mid-stream
                    if (mix == 1 && setting == 1 && n == 75) begin
                        drain();
                    end
                    push_cmd(random_cmd(), 1'b0, 32'h0);
                end
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("velocity_lqr_integral_controller test passed");
        end else begin
            $display("velocity_lqr_integral_controller test failed");
        end
        $finish;
    end

endmodule
